>>> rtl/stable_index_sort_core_macros.svh
// Assertion macros for the stable index sort core.
`ifndef STABLE_INDEX_SORT_CORE_MACROS_SVH
`define STABLE_INDEX_SORT_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SIS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SIS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sis_pkg.sv
// Shared types and constants for the stable index sort core.
`timescale 1ns / 1ps
`default_nettype none
package sis_pkg;
    localparam int KEY_IN_W      = 32;
    localparam int POS_W         = 6;
    localparam int MAX_KEYS_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    typedef struct packed {
        logic signed [KEY_IN_W-1:0] key_value;
        logic                       set_end;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] sorted_position;
        logic             run_end;
        logic             overflow_flag;
    } t_out_item;
endpackage
`default_nettype wire

>>> rtl/sis_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/stable_index_sort_core.sv
// Stable argsort core: loads keys, bubble-sorts their positions, emits the order.
//
// Usage: drive an item on i_item and raise start; it is taken at an edge where
// busy is low. Each item stores one signed key; the item with set_end closes the
// set. Keys beyond MAX_KEYS are dropped and flag overflow on every result.
// Load items are taken one per cycle while busy is low and give no result.
// After the closing item busy rises. The sort streams bubble passes through the
// order memory, one compare per cycle, each pass one entry shorter than the last.
// Results then leave one per cycle on o_result, marked by o_res_strobe; the last
// carries run_end. busy falls as the last result is shown, and the next set may
// load at once. The receiver cannot stall; every strobe is a taken result.
// Reset (synchronous, active low) empties the store and returns to loading.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_index_sort_core_macros.svh"
module stable_index_sort_core #(
    parameter int MAX_KEYS  = sis_pkg::MAX_KEYS_DEF,
    parameter int KEY_WIDTH = sis_pkg::KEY_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sis_pkg::t_in_item i_item,
    output logic                   o_res_strobe,
    output sis_pkg::t_out_item     o_result
);
    import sis_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int KEY_W = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_s1_v, r_s2_v, r_o_v;
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s2_pos;
    logic [IDX_W-1:0] r_c_pos;
    logic [KEY_W-1:0] r_c_key;
    logic             r_o_last, r_o_ovf;

    logic             w_acc, w_store, w_issue, w_cmp, w_gt, w_pass_end;
    logic [CNT_W-1:0] w_limit;
    logic             w_ord_we;
    logic [IDX_W-1:0] w_ord_waddr, w_ord_wdata, w_ord_rdata;
    logic [KEY_W-1:0] w_key_rdata;

    assign busy       = (r_state != ST_LOAD);
    assign w_acc      = start && !busy;
    assign w_store    = w_acc && (r_count != CNT_W'(MAX_KEYS));
    assign w_limit    = (r_state == ST_PASS) ? r_len : r_count;
    assign w_issue    = ((r_state == ST_PASS) || (r_state == ST_OUT)) && (r_rd_idx != w_limit);
    assign w_cmp      = r_s2_v && (r_s2_idx != '0);
    assign w_gt       = $signed(r_c_key) > $signed(w_key_rdata);
    assign w_pass_end = r_s2_v && (r_s2_idx == IDX_W'(r_len - 1'b1));

    sis_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_mem (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_item.key_value[KEY_W-1:0]),
        .i_raddr (w_ord_rdata),
        .o_rdata (w_key_rdata)
    );

    sis_ram #(.WIDTH(IDX_W), .DEPTH(MAX_KEYS)) u_ord_mem (
        .i_clk   (i_clk),
        .i_we    (w_ord_we),
        .i_waddr (w_ord_waddr),
        .i_wdata (w_ord_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_ord_rdata)
    );

    // order memory write: identity on load, bubble writes in pass, carry at pass tail
    always_comb begin
        w_ord_we    = 1'b0;
        w_ord_waddr = r_count[IDX_W-1:0];
        w_ord_wdata = r_count[IDX_W-1:0];
        case (r_state)
            ST_LOAD: begin
                w_ord_we = w_store;
            end
            ST_PASS: begin
                w_ord_we    = w_cmp;
                w_ord_waddr = r_s2_idx - 1'b1;
                w_ord_wdata = w_gt ? r_s2_pos : r_c_pos;
            end
            ST_TAIL: begin
                w_ord_we    = 1'b1;
                w_ord_waddr = IDX_W'(r_len - 1'b1);
                w_ord_wdata = r_c_pos;
            end
            default: begin
                w_ord_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_len    = r_len;
        n_rd_idx = r_rd_idx;
        if (w_issue) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
        case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    if (w_store) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.set_end) begin
                        n_len    = n_count;
                        n_rd_idx = '0;
                        n_state  = (n_count > CNT_W'(1)) ? ST_PASS : ST_OUT;
                    end
                end
            end
            ST_PASS: begin
                if (w_pass_end) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_len    = r_len - 1'b1;
                n_rd_idx = '0;
                n_state  = (n_len > CNT_W'(1)) ? ST_PASS : ST_OUT;
            end
            ST_OUT: begin
                if (w_issue && (r_rd_idx == r_count - 1'b1)) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_len    <= '0;
            r_rd_idx <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_len    <= n_len;
            r_rd_idx <= n_rd_idx;
            r_s1_v   <= w_issue && (r_state == ST_PASS);
            r_s2_v   <= r_s1_v;
            r_o_v    <= w_issue && (r_state == ST_OUT);
        end
    end

    // carry holds the larger key bubbling up through the pass
    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_rd_idx[IDX_W-1:0];
        r_s2_idx <= r_s1_idx;
        r_s2_pos <= w_ord_rdata;
        r_o_last <= (r_rd_idx == r_count - 1'b1);
        r_o_ovf  <= r_ovf;
        if (r_s2_v && ((r_s2_idx == '0) || !w_gt)) begin
            r_c_pos <= r_s2_pos;
            r_c_key <= w_key_rdata;
        end
    end

    assign o_res_strobe             = r_o_v;
    assign o_result.sorted_position = POS_W'(w_ord_rdata);
    assign o_result.run_end         = r_o_last;
    assign o_result.overflow_flag   = r_o_ovf;

    `SIS_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(MAX_KEYS), "key count above store depth")
    `SIS_ASSERT_SAME(a_s2_in_pass, r_s2_v, r_state == ST_PASS, "compare stage active outside a pass")
    `SIS_ASSERT_NEXT(a_close_busy, start && !busy && i_item.set_end, busy, "closing item did not start sort")
    `SIS_ASSERT_NEXT(a_run_end_gap, o_res_strobe && o_result.run_end, !o_res_strobe, "result after run end")
endmodule
`default_nettype wire
